/* hw/rtl/e2bv_pkg.sv */
// ----------------------------------------------------------------------------
// e2bv_pkg
// Shared constants, types and the quarter-wave sine series for the
// Euler-angle to basis-vector pipeline.
// ----------------------------------------------------------------------------
package e2bv_pkg;

  localparam int AngW      = 16;
  localparam int QW        = 16;
  localparam int QuarterSt = 5760;
  localparam int TurnSt    = 23040;
  localparam int Q14One    = 16384;
  localparam int RemW      = 13;
  localparam int ProdW     = 48;
  localparam int ProdFrac  = 42;

  typedef logic signed [QW-1:0] q14_t;

  typedef struct packed {
    q14_t sn;
    q14_t cs;
  } sc_t;

  // sin(r*pi/11520) in Q14, r in [0,5760], with the same rounding as the
  // Horner series; fills the quarter-wave tables at start-up.
  function automatic logic [14:0] quarter_sine(input logic [RemW-1:0] r_in);
    logic [63:0] theta, u, h, s, rr;
    rr = (r_in > RemW'(QuarterSt)) ? 64'(QuarterSt) : 64'(r_in);
    theta = (rr * 64'd299845282 + 64'd512) >> 10;
    u = (theta * theta + (64'd1 << 29)) >> 30;
    h = (64'd1 << 30) - u / 64'd110;
    h = (64'd1 << 30) - ((u * h + (64'd1 << 29)) >> 30) / 64'd72;
    h = (64'd1 << 30) - ((u * h + (64'd1 << 29)) >> 30) / 64'd42;
    h = (64'd1 << 30) - ((u * h + (64'd1 << 29)) >> 30) / 64'd20;
    h = (64'd1 << 30) - ((u * h + (64'd1 << 29)) >> 30) / 64'd6;
    s = (((theta * h + (64'd1 << 29)) >> 30) + 64'd32768) >> 16;
    if (s > 64'(Q14One)) s = 64'(Q14One);
    return s[14:0];
  endfunction

endpackage

/* hw/rtl/euler_to_basis_vectors_core.sv */
// ----------------------------------------------------------------------------
// euler_to_basis_vectors_core
// Yaw/pitch/roll (1/64 degree) to forward, left and up basis vectors, Q1.14.
//
// Usage: drive in_valid with the three angles; a word is taken when in_valid
// and in_ready are high. Results leave on out_valid/out_ready, one word per
// input word, in order. Each accepted word passes through five register
// stages (reduce and table read, quadrant signs, two-factor products,
// three-factor sums, rounding) before out_valid rises for it. Throughput is
// one word per cycle while the output is not stalled, set by the five-stage
// pipeline with a valid bit per stage.
// When the receiver stalls, the whole pipeline holds; in_ready falls only
// while the last stage holds an untaken word, so nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; no words are in
// flight afterwards. Payload registers are not reset.
// ----------------------------------------------------------------------------
module euler_to_basis_vectors_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [15:0] in_yaw_angle,
  input  logic signed [15:0] in_pitch_angle,
  input  logic signed [15:0] in_roll_angle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_fwd_x,
  output logic signed [15:0] out_fwd_y,
  output logic signed [15:0] out_fwd_z,
  output logic signed [15:0] out_left_x,
  output logic signed [15:0] out_left_y,
  output logic signed [15:0] out_left_z,
  output logic signed [15:0] out_up_x,
  output logic signed [15:0] out_up_y,
  output logic signed [15:0] out_up_z
);

  logic [4:0] v_r, v_nxt;
  logic       en;
  e2bv_pkg::sc_t scy, scp, scr;

  assign en       = !v_r[4] || out_ready;
  assign in_ready = en;
  assign out_valid = v_r[4];

  always_comb begin
    v_nxt = {v_r[3:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= v_nxt;
  end

  e2bv_sincos u_sy (.clk(clk), .en(en), .ang(in_yaw_angle),   .sc(scy));
  e2bv_sincos u_sp (.clk(clk), .en(en), .ang(in_pitch_angle), .sc(scp));
  e2bv_sincos u_sr (.clk(clk), .en(en), .ang(in_roll_angle),  .sc(scr));

  // stage three: pairwise products (Q28) and carried factors
  logic signed [31:0] cpcy_r, cpsy_r, cpsr_r, cpcr_r, sp_r;
  logic signed [31:0] cysp_r, sysp_r, crcy_r, crsy_r, crsyq_r, crcyq_r;
  logic signed [31:0] srsyq_r, srcyq_r;
  logic signed [15:0] sr3_r, cr3_r, sp3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cpcy_r  <= scp.cs * scy.cs;
      cpsy_r  <= scp.cs * scy.sn;
      cpsr_r  <= scp.cs * scr.sn;
      cpcr_r  <= scp.cs * scr.cs;
      sp_r    <= 32'(scp.sn);
      cysp_r  <= scy.cs * scp.sn;
      sysp_r  <= scy.sn * scp.sn;
      crcy_r  <= scr.cs * scy.cs;
      crsy_r  <= scr.cs * scy.sn;
      crsyq_r <= scr.cs * scy.sn;
      crcyq_r <= scr.cs * scy.cs;
      srsyq_r <= scr.sn * scy.sn;
      srcyq_r <= scr.sn * scy.cs;
      sr3_r   <= scr.sn;
      cr3_r   <= scr.cs;
      sp3_r   <= scp.sn;
    end
  end

  // stage four: sums and products in Q42
  logic signed [e2bv_pkg::ProdW-1:0] lx_r, ly_r, ux_r, uy_r;
  logic signed [e2bv_pkg::ProdW-1:0] fx_r, fy_r, lz_r, uz_r;
  logic signed [15:0] fz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lx_r <= e2bv_pkg::ProdW'(cysp_r) * e2bv_pkg::ProdW'(sr3_r)
              - (e2bv_pkg::ProdW'(crsyq_r) <<< 14);
      ly_r <= e2bv_pkg::ProdW'(sysp_r) * e2bv_pkg::ProdW'(sr3_r)
              + (e2bv_pkg::ProdW'(crcyq_r) <<< 14);
      ux_r <= e2bv_pkg::ProdW'(crcy_r) * e2bv_pkg::ProdW'(sp3_r)
              + (e2bv_pkg::ProdW'(srsyq_r) <<< 14);
      uy_r <= e2bv_pkg::ProdW'(crsy_r) * e2bv_pkg::ProdW'(sp3_r)
              - (e2bv_pkg::ProdW'(srcyq_r) <<< 14);
      fx_r <= e2bv_pkg::ProdW'(cpcy_r) <<< 14;
      fy_r <= e2bv_pkg::ProdW'(cpsy_r) <<< 14;
      lz_r <= e2bv_pkg::ProdW'(cpsr_r) <<< 14;
      uz_r <= e2bv_pkg::ProdW'(cpcr_r) <<< 14;
      fz_r <= -16'(sp_r);
    end
  end

  e2bv_pkg::q14_t q_fx, q_fy, q_lx, q_ly, q_lz, q_ux, q_uy, q_uz;

  e2bv_round u_rfx (.p(fx_r), .q(q_fx));
  e2bv_round u_rfy (.p(fy_r), .q(q_fy));
  e2bv_round u_rlz (.p(lz_r), .q(q_lz));
  e2bv_round u_ruz (.p(uz_r), .q(q_uz));
  e2bv_round u_rlx (.p(lx_r), .q(q_lx));
  e2bv_round u_rly (.p(ly_r), .q(q_ly));
  e2bv_round u_rux (.p(ux_r), .q(q_ux));
  e2bv_round u_ruy (.p(uy_r), .q(q_uy));

  always_ff @(posedge clk) begin
    if (en) begin
      out_fwd_x  <= q_fx;
      out_fwd_y  <= q_fy;
      out_fwd_z  <= fz_r;
      out_left_x <= q_lx;
      out_left_y <= q_ly;
      out_left_z <= q_lz;
      out_up_x   <= q_ux;
      out_up_y   <= q_uy;
      out_up_z   <= q_uz;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_up_z))
    else $error("result dropped under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fwd_x <= 16'sd16384 && out_fwd_x >= -16'sd16384))
    else $error("result out of range");

endmodule

/* hw/rtl/e2bv_sincos.sv */
// ----------------------------------------------------------------------------
// e2bv_sincos
// Two-stage sine/cosine: stage one reduces the angle to quadrant and
// remainder and reads the quarter-wave table at the remainder and its
// complement, stage two applies the quadrant signs.
// ----------------------------------------------------------------------------
module e2bv_sincos (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [e2bv_pkg::AngW-1:0] ang,
  output e2bv_pkg::sc_t                 sc
);

  logic [14:0]        sine_rom [0:e2bv_pkg::QuarterSt];
  logic signed [15:0] a_mod;
  logic [14:0]        a_pos;
  logic [1:0]         q_nxt, q_r;
  logic [e2bv_pkg::RemW-1:0] r_nxt;
  logic [e2bv_pkg::RemW-1:0] rc_nxt;
  logic [14:0]        s0_r, s1_r;
  e2bv_pkg::sc_t      sc_nxt, sc_r;

  initial begin
    for (int i = 0; i <= e2bv_pkg::QuarterSt; i++)
      sine_rom[i] = e2bv_pkg::quarter_sine(e2bv_pkg::RemW'(i));
  end

  // |ang| < 2*23040, so reduction needs at most two corrections
  always_comb begin
    a_mod = ang;
    if (a_mod >= 16'sd23040) a_mod = a_mod - 16'sd23040;
    else if (a_mod < 16'sd0) begin
      a_mod = a_mod + 16'sd23040;
      if (a_mod < 16'sd0) a_mod = a_mod + 16'sd23040;
    end
    a_pos = a_mod[14:0];
    if (a_pos >= 15'd17280) begin
      q_nxt = 2'd3; r_nxt = e2bv_pkg::RemW'(a_pos - 15'd17280);
    end else if (a_pos >= 15'd11520) begin
      q_nxt = 2'd2; r_nxt = e2bv_pkg::RemW'(a_pos - 15'd11520);
    end else if (a_pos >= 15'd5760) begin
      q_nxt = 2'd1; r_nxt = e2bv_pkg::RemW'(a_pos - 15'd5760);
    end else begin
      q_nxt = 2'd0; r_nxt = e2bv_pkg::RemW'(a_pos);
    end
    rc_nxt = e2bv_pkg::RemW'(e2bv_pkg::QuarterSt) - r_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r  <= q_nxt;
      s0_r <= sine_rom[r_nxt];
      s1_r <= sine_rom[rc_nxt];
    end
  end

  always_comb begin
    case (q_r)
      2'd0: begin sc_nxt.sn =  16'(s0_r); sc_nxt.cs =  16'(s1_r); end
      2'd1: begin sc_nxt.sn =  16'(s1_r); sc_nxt.cs = -16'(s0_r); end
      2'd2: begin sc_nxt.sn = -16'(s0_r); sc_nxt.cs = -16'(s1_r); end
      default: begin sc_nxt.sn = -16'(s1_r); sc_nxt.cs = 16'(s0_r); end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) sc_r <= sc_nxt;
  end

  assign sc = sc_r;

endmodule

/* hw/rtl/e2bv_round.sv */
// ----------------------------------------------------------------------------
// e2bv_round
// Rounds a signed Q42 value to Q14, halves away from zero, clamped.
// ----------------------------------------------------------------------------
module e2bv_round (
  input  logic signed [e2bv_pkg::ProdW-1:0] p,
  output e2bv_pkg::q14_t                    q
);

  logic [e2bv_pkg::ProdW-1:0] mag;
  logic [e2bv_pkg::ProdW-1:0] rnd;

  always_comb begin
    mag = p[e2bv_pkg::ProdW-1] ? e2bv_pkg::ProdW'(-p) : e2bv_pkg::ProdW'(p);
    rnd = (mag + (e2bv_pkg::ProdW'(1) << (e2bv_pkg::ProdFrac - 15)))
          >> (e2bv_pkg::ProdFrac - 14);
    if (rnd > e2bv_pkg::ProdW'(e2bv_pkg::Q14One)) rnd = e2bv_pkg::ProdW'(e2bv_pkg::Q14One);
    q = p[e2bv_pkg::ProdW-1] ? -16'(rnd) : 16'(rnd);
  end

endmodule
